@@ src/bdrm_pkg.sv @@
package bdrm_pkg;

  localparam int DictEntries = 1024;
  localparam int DescWords   = 4;
  localparam int IdxW        = $clog2(DictEntries);
  localparam int WSelW       = (DescWords > 1) ? $clog2(DescWords) : 1;
  localparam int CntW        = IdxW + 1;
  localparam int DistW       = 9;
  localparam logic [7:0] ScaleUnknown = 8'd255;
  localparam logic [DistW:0] NoDist = {1'b1, {DistW{1'b0}}};

  localparam logic [2:0] CfgRadius   = 3'd0;
  localparam logic [2:0] CfgMaxHam   = 3'd1;
  localparam logic [2:0] CfgRatioOn  = 3'd2;
  localparam logic [2:0] CfgRatioThr = 3'd3;
  localparam logic [2:0] CfgScalePf  = 3'd4;
  localparam logic [2:0] CfgEntries  = 3'd5;

  localparam logic [1:0] StMatched = 2'd0;
  localparam logic [1:0] StNone    = 2'd1;
  localparam logic [1:0] StRatio   = 2'd2;
  localparam logic [1:0] StScale   = 2'd3;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDecide,
    StOut
  } state_e;

  // beat moving down the cell chain
  typedef struct packed {
    logic             valid;
    logic             keep;
    logic [IdxW-1:0]  idx;
    logic [7:0]       scale;
    logic [DistW-1:0] ham;
  } cand_t;

endpackage

@@ src/binary_descriptor_ratio_matcher_top.sv @@
// Brute-force two-nearest Hamming matcher with ratio and scale tests. Load
// beats (kind 0) write one dictionary word plus the entry's position and scale;
// query beats (kind 1) store query words, and the last word starts a scan of
// entries 0 .. entries_in_use-1. The scan reads one entry per cycle and feeds
// a chain of DescWords popcount cells, one word per cell. The result waits for
// the pipeline to drain and for a still waiting result to be taken; the input
// is held off meanwhile. One result beat is given per query; tdata = {status,
// match_index, match_distance, match_scale} from bit 0 up. Configuration is to
// be written while idle; the user must ensure this, as the block has no check.
module binary_descriptor_ratio_matcher_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // entry_index, word_index, descriptor_word,
                                      // point_x, point_y, point_scale
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // status, match_index, match_distance, match_scale
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int IdxW  = bdrm_pkg::IdxW;
  localparam int CntW  = bdrm_pkg::CntW;
  localparam int DistW = bdrm_pkg::DistW;
  localparam int DW    = bdrm_pkg::DescWords;
  localparam int WSelW = bdrm_pkg::WSelW;

  logic [IdxW-1:0] in_entry;
  logic [1:0]      in_word;
  logic [63:0]     in_dword;
  logic [15:0]     in_x, in_y;
  logic [7:0]      in_s;
  assign in_entry = s_axis_tdata[9:0];
  assign in_word  = s_axis_tdata[11:10];
  assign in_dword = s_axis_tdata[75:12];
  assign in_x     = s_axis_tdata[91:76];
  assign in_y     = s_axis_tdata[107:92];
  assign in_s     = s_axis_tdata[115:108];

  // config
  logic [15:0]      radius_q;
  logic [DistW-1:0] maxham_q, thr_q;
  logic             ratio_on_q, scale_pf_q;
  logic [CntW-1:0]  entries_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= 16'd256;
      maxham_q   <= 9'd64;
      ratio_on_q <= 1'b1;
      thr_q      <= 9'd205;
      scale_pf_q <= 1'b0;
      entries_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bdrm_pkg::CfgRadius:   radius_q   <= cfg_data_i;
        bdrm_pkg::CfgMaxHam:   maxham_q   <= cfg_data_i[8:0];
        bdrm_pkg::CfgRatioOn:  ratio_on_q <= cfg_data_i[0];
        bdrm_pkg::CfgRatioThr: thr_q      <= cfg_data_i[8:0];
        bdrm_pkg::CfgScalePf:  scale_pf_q <= cfg_data_i[0];
        bdrm_pkg::CfgEntries:  entries_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  bdrm_pkg::state_e state_q, state_d;
  logic in_acc, scan_start;
  logic [IdxW:0]   scan_cnt_q, scan_cnt_d, count_lim;
  logic [15:0]     qx_q, qy_q;
  logic [7:0]      qs_q;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign scan_start = in_acc && s_axis_tuser && (in_word == 2'(DW - 1));
  assign count_lim = (entries_q > CntW'(bdrm_pkg::DictEntries)) ?
                     CntW'(bdrm_pkg::DictEntries) : entries_q;

  // stores
  logic [15:0] mem_x [bdrm_pkg::DictEntries];
  logic [15:0] mem_y [bdrm_pkg::DictEntries];
  logic [7:0]  mem_s [bdrm_pkg::DictEntries];
  logic [63:0] mem_d [DW][bdrm_pkg::DictEntries];
  logic [63:0] qd_q  [DW];

  logic            ld_we;
  logic [IdxW-1:0] rd_addr;
  assign ld_we   = in_acc && !s_axis_tuser && (32'(in_word) < DW);
  assign rd_addr = scan_cnt_q[IdxW-1:0];

  logic [15:0]      rx_q, ry_q;
  logic [7:0]       rs_q;
  logic [63:0]      rd_q [DW];
  logic             rv_q;
  logic [IdxW-1:0]  ri_q;

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      mem_x[in_entry] <= in_x;
      mem_y[in_entry] <= in_y;
      mem_s[in_entry] <= in_s;
    end
    rx_q <= mem_x[rd_addr];
    ry_q <= mem_y[rd_addr];
    rs_q <= mem_s[rd_addr];
    ri_q <= rd_addr;
  end

  for (genvar w = 0; w < DW; w++) begin : g_mem
    always_ff @(posedge clk_i) begin
      if (ld_we && in_word[WSelW-1:0] == WSelW'(w)) begin
        mem_d[w][in_entry] <= in_dword;
      end
      rd_q[w] <= mem_d[w][rd_addr];
      if (in_acc && s_axis_tuser && in_word[WSelW-1:0] == WSelW'(w)) begin
        qd_q[w] <= in_dword;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_start) begin
      qx_q <= in_x;
      qy_q <= in_y;
      qs_q <= in_s;
    end
  end

  // stage: squared distance
  logic [15:0] dx, dy;
  logic [31:0] dx2_q, dy2_q;
  logic [31:0] r2_q;
  logic        e_v_q, e_sok_q;
  logic [IdxW-1:0] e_i_q;
  logic [7:0]  e_s_q;
  logic [63:0] e_d_q [DW];
  assign dx = (qx_q > rx_q) ? qx_q - rx_q : rx_q - qx_q;
  assign dy = (qy_q > ry_q) ? qy_q - ry_q : ry_q - qy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_v_q <= 1'b0;
    else         e_v_q <= rv_q;
  end
  always_ff @(posedge clk_i) begin
    dx2_q   <= dx * dx;
    dy2_q   <= dy * dy;
    r2_q    <= radius_q * radius_q;
    e_i_q   <= ri_q;
    e_s_q   <= rs_q;
    e_sok_q <= !scale_pf_q || (rs_q == qs_q);
    e_d_q   <= rd_q;
  end

  bdrm_pkg::cand_t chain [DW+1];
  logic [63:0] cd_q [DW][DW];

  always_comb begin
    chain[0].valid = e_v_q;
    chain[0].keep  = e_sok_q && ({1'b0, r2_q} >= ({1'b0, dx2_q} + {1'b0, dy2_q}));
    chain[0].idx   = e_i_q;
    chain[0].scale = e_s_q;
    chain[0].ham   = '0;
  end

  // descriptor words delayed to line up with their cell
  for (genvar c = 0; c < DW; c++) begin : g_cell
    if (c == 0) begin : g_first
      assign cd_q[0] = e_d_q;
    end else begin : g_rest
      always_ff @(posedge clk_i) cd_q[c] <= cd_q[c-1];
    end
    bdrm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cand_i   (chain[c]),
      .q_word_i (qd_q[c]),
      .d_word_i (cd_q[c][c]),
      .cand_o   (chain[c+1])
    );
  end

  // best two
  bdrm_pkg::cand_t tail;
  logic [DistW:0]  bd_q, sd_q;
  logic [IdxW-1:0] bi_q;
  logic [7:0]      bs_q;
  logic            hit;
  assign tail = chain[DW];
  assign hit  = tail.valid && tail.keep && (tail.ham <= maxham_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bd_q <= bdrm_pkg::NoDist;
      sd_q <= bdrm_pkg::NoDist;
    end else if (scan_start) begin
      bd_q <= bdrm_pkg::NoDist;
      sd_q <= bdrm_pkg::NoDist;
    end else if (hit) begin
      if ({1'b0, tail.ham} < bd_q) begin
        sd_q <= bd_q;
        bd_q <= {1'b0, tail.ham};
      end else if ({1'b0, tail.ham} < sd_q) begin
        sd_q <= {1'b0, tail.ham};
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (hit && ({1'b0, tail.ham} < bd_q)) begin
      bi_q <= tail.idx;
      bs_q <= tail.scale;
    end
  end

  // drain counter for the pipeline tail
  localparam int Lat = DW + 3;
  logic [3:0] drain_q, drain_d;

  // decision
  logic [17:0] lhs, rhs;
  logic        rej_ratio, rej_scale;
  logic [7:0]  sdiff;
  logic [1:0]  st_d;
  logic        out_v_q;
  logic [31:0] out_q, out_d;
  assign lhs = {bd_q[DistW-1:0], 8'h00} & 18'h3FFFF;
  assign rhs = thr_q * sd_q[DistW-1:0];
  assign rej_ratio = !sd_q[DistW] &&
                     (ratio_on_q ? (lhs >= rhs) : (bd_q >= sd_q));
  assign sdiff = (qs_q > bs_q) ? qs_q - bs_q : bs_q - qs_q;
  assign rej_scale = (sdiff > 8'd1) && (bs_q != bdrm_pkg::ScaleUnknown) &&
                     (qs_q != bdrm_pkg::ScaleUnknown);

  always_comb begin
    priority if (bd_q[DistW])  st_d = bdrm_pkg::StNone;
    else if (rej_ratio)        st_d = bdrm_pkg::StRatio;
    else if (rej_scale)        st_d = bdrm_pkg::StScale;
    else                       st_d = bdrm_pkg::StMatched;
  end

  always_comb begin
    out_d = '0;
    out_d[1:0] = st_d;
    if (!bd_q[DistW]) begin
      out_d[11:2]  = bi_q;
      out_d[20:12] = bd_q[DistW-1:0];
      out_d[28:21] = bs_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    drain_d    = drain_q;
    unique case (state_q)
      bdrm_pkg::StIdle: begin
        if (scan_start) begin
          state_d    = bdrm_pkg::StScan;
          scan_cnt_d = '0;
        end
      end
      bdrm_pkg::StScan: begin
        if (scan_cnt_q >= count_lim) begin
          state_d = bdrm_pkg::StDecide;
          drain_d = 4'(Lat);
        end else begin
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      bdrm_pkg::StDecide: begin
        if (drain_q == '0) state_d = bdrm_pkg::StOut;
        else               drain_d = drain_q - 1'b1;
      end
      bdrm_pkg::StOut: begin
        if (!out_v_q || m_axis_tready) state_d = bdrm_pkg::StIdle;
      end
      default: state_d = bdrm_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bdrm_pkg::StIdle;
      scan_cnt_q <= '0;
      drain_q    <= '0;
      rv_q       <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      drain_q    <= drain_d;
      rv_q       <= (state_q == bdrm_pkg::StScan) && (scan_cnt_q < count_lim);
      if (state_q == bdrm_pkg::StOut && (!out_v_q || m_axis_tready)) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bdrm_pkg::StOut && (!out_v_q || m_axis_tready)) begin
      out_q <= out_d;
    end
  end

  assign s_axis_tready = (state_q == bdrm_pkg::StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == bdrm_pkg::StIdle) else $error("ready outside idle");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bd_q[DistW] |-> bd_q <= sd_q) else $error("best worse than second");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_start |=> state_q == bdrm_pkg::StScan) else $error("scan not started");

endmodule

@@ src/bdrm_cell.sv @@
// One popcount cell: adds the Hamming count of one descriptor word.
module bdrm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bdrm_pkg::cand_t    cand_i,
  input  logic [63:0]        q_word_i,
  input  logic [63:0]        d_word_i,
  output bdrm_pkg::cand_t    cand_o
);

  bdrm_pkg::cand_t cand_q, cand_d;
  logic [6:0] pc;

  always_comb begin
    pc = '0;
    for (int b = 0; b < 64; b++) begin
      pc = pc + 7'(q_word_i[b] ^ d_word_i[b]);
    end
    cand_d     = cand_i;
    cand_d.ham = cand_i.ham + bdrm_pkg::DistW'(pc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule
